### src/clds_pkg.sv
// clds_pkg: shared types and codes for the circular list deque with search
// depends on nothing; used by clds_ram, clds_ctrl and circular_list_deque_with_search
`timescale 1ns / 1ps

package clds_pkg;

    localparam int DataW   = 32;
    localparam int ReqW    = 3;
    localparam int StatusW = 2;
    localparam int PosW    = 4;
    localparam int OccW    = 5;

    typedef logic [ReqW-1:0] t_req;

    localparam t_req REQ_INS_FRONT = 3'd0;
    localparam t_req REQ_INS_BACK  = 3'd1;
    localparam t_req REQ_REM_FRONT = 3'd2;
    localparam t_req REQ_REM_BACK  = 3'd3;
    localparam t_req REQ_REM_VALUE = 3'd4;
    localparam t_req REQ_SEARCH    = 3'd5;

    typedef enum logic [StatusW-1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FETCH,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status                   status;
        logic signed [DataW-1:0]   removed_value;
        logic [PosW-1:0]           position;
        logic [OccW-1:0]           occupancy;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
    } t_ctrl_sts;

endpackage

### src/clds_ram.sv
// clds_ram: entry store, one write port and one read port with registered read data
// depends on clds_pkg for the data width
`timescale 1ns / 1ps

module clds_ram #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  logic [clds_pkg::DataW-1:0]    i_wdata,
    input  logic [$clog2(DEPTH)-1:0]      i_raddr,
    output logic [clds_pkg::DataW-1:0]    o_rdata
);

    logic [clds_pkg::DataW-1:0] r_mem [DEPTH];
    logic [clds_pkg::DataW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/clds_ctrl.sv
// clds_ctrl: request sequencer, slot address adders, match compare and the entry store
// depends on clds_pkg and clds_ram
`timescale 1ns / 1ps

module clds_ctrl #(
    parameter int CAPACITY = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  clds_pkg::t_req                i_req_type,
    input  logic [clds_pkg::DataW-1:0]    i_value,
    input  logic                          i_out_free,
    output clds_pkg::t_ctrl_sts           o_sts,
    output clds_pkg::t_result             o_result
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    clds_pkg::t_state  r_state, n_state;
    clds_pkg::t_req    r_req;
    clds_pkg::t_status r_status, n_status;

    logic [clds_pkg::DataW-1:0] r_value;
    logic [clds_pkg::DataW-1:0] r_removed, n_removed;
    logic [AW-1:0]              r_head, n_head;
    logic [CW-1:0]              r_count, n_count;
    logic [AW-1:0]              r_idx, n_idx;
    logic [AW-1:0]              r_pos, n_pos;

    logic                       w_we;
    logic [CW:0]                w_woff;
    logic [CW:0]                w_roff;
    logic [AW-1:0]              w_waddr;
    logic [AW-1:0]              w_raddr;
    logic [clds_pkg::DataW-1:0] w_wdata;
    logic [clds_pkg::DataW-1:0] w_rdata;

    logic                       w_full;
    logic                       w_empty;
    logic                       w_match;
    logic [CW:0]                w_idx_p1;
    logic [CW:0]                w_idx_p2;
    logic                       w_scan_last;
    logic                       w_shift_last;
    logic [AW+clds_pkg::PosW-1:0] w_pos_ext;
    logic [CW+clds_pkg::OccW-1:0] w_occ_ext;

    // head plus offset, folded back into the ring (sum stays below twice the capacity)
    function automatic logic [AW-1:0] f_slot(input logic [CW+1:0] sum);
        logic [CW+1:0] folded;
        folded = (sum >= (CW+2)'(CAPACITY)) ? sum - (CW+2)'(CAPACITY) : sum;
        return folded[AW-1:0];
    endfunction

    assign w_full       = (r_count == CW'(CAPACITY));
    assign w_empty      = (r_count == '0);
    assign w_match      = (w_rdata == r_value);
    assign w_idx_p1     = (CW+1)'(r_idx) + (CW+1)'(1);
    assign w_idx_p2     = (CW+1)'(r_idx) + (CW+1)'(2);
    assign w_scan_last  = (w_idx_p1 >= {1'b0, r_count});
    assign w_shift_last = (w_idx_p2 >= {1'b0, r_count});

    assign w_waddr = f_slot((CW+2)'(r_head) + (CW+2)'(w_woff));
    assign w_raddr = f_slot((CW+2)'(r_head) + (CW+2)'(w_roff));

    clds_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            clds_pkg::S_IDLE: begin
                if (i_start) begin
                    n_state = clds_pkg::S_DECODE;
                end
            end
            clds_pkg::S_DECODE: begin
                case (r_req)
                    clds_pkg::REQ_REM_FRONT,
                    clds_pkg::REQ_REM_BACK: begin
                        n_state = w_empty ? clds_pkg::S_DONE : clds_pkg::S_FETCH;
                    end
                    clds_pkg::REQ_REM_VALUE,
                    clds_pkg::REQ_SEARCH: begin
                        n_state = w_empty ? clds_pkg::S_DONE : clds_pkg::S_SCAN;
                    end
                    default: begin
                        n_state = clds_pkg::S_DONE;
                    end
                endcase
            end
            clds_pkg::S_FETCH: begin
                n_state = clds_pkg::S_DONE;
            end
            clds_pkg::S_SCAN: begin
                if (w_match) begin
                    n_state = (r_req == clds_pkg::REQ_REM_VALUE && !w_scan_last)
                            ? clds_pkg::S_SHIFT : clds_pkg::S_DONE;
                end else if (w_scan_last) begin
                    n_state = clds_pkg::S_DONE;
                end
            end
            clds_pkg::S_SHIFT: begin
                if (w_shift_last) begin
                    n_state = clds_pkg::S_DONE;
                end
            end
            clds_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = clds_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = clds_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and store control
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_status  = r_status;
        n_removed = r_removed;
        w_we      = 1'b0;
        w_woff    = '0;
        w_roff    = '0;
        w_wdata   = r_value;
        case (r_state)
            clds_pkg::S_DECODE: begin
                n_status  = clds_pkg::ST_OK;
                n_removed = '0;
                n_pos     = '0;
                n_idx     = '0;
                case (r_req)
                    clds_pkg::REQ_INS_FRONT: begin
                        if (w_full) begin
                            n_status = clds_pkg::ST_FULL;
                        end else begin
                            // one slot before the head, wrapping
                            w_woff  = (CW+1)'(CAPACITY - 1);
                            w_we    = 1'b1;
                            n_head  = f_slot((CW+2)'(r_head) + (CW+2)'(CAPACITY - 1));
                            n_count = r_count + CW'(1);
                        end
                    end
                    clds_pkg::REQ_INS_BACK: begin
                        if (w_full) begin
                            n_status = clds_pkg::ST_FULL;
                        end else begin
                            w_woff  = {1'b0, r_count};
                            w_we    = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    clds_pkg::REQ_REM_FRONT,
                    clds_pkg::REQ_REM_VALUE: begin
                        if (w_empty) begin
                            n_status = clds_pkg::ST_EMPTY;
                        end
                    end
                    clds_pkg::REQ_REM_BACK: begin
                        if (w_empty) begin
                            n_status = clds_pkg::ST_EMPTY;
                        end else begin
                            w_roff = {1'b0, r_count} - (CW+1)'(1);
                        end
                    end
                    clds_pkg::REQ_SEARCH: begin
                        if (w_empty) begin
                            n_status = clds_pkg::ST_NOTFOUND;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            clds_pkg::S_FETCH: begin
                n_removed = w_rdata;
                n_count   = r_count - CW'(1);
                if (r_req == clds_pkg::REQ_REM_FRONT) begin
                    n_head = f_slot((CW+2)'(r_head) + (CW+2)'(1));
                end
            end
            clds_pkg::S_SCAN: begin
                // read of the next entry overlaps the compare of this one
                w_roff = w_idx_p1;
                if (w_match) begin
                    n_pos = r_idx;
                    if (r_req == clds_pkg::REQ_REM_VALUE) begin
                        n_removed = w_rdata;
                        if (w_scan_last) begin
                            n_count = r_count - CW'(1);
                        end
                    end
                end else if (w_scan_last) begin
                    n_status = clds_pkg::ST_NOTFOUND;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            clds_pkg::S_SHIFT: begin
                // pull the entry behind into this slot, fetch the one after it
                w_we    = 1'b1;
                w_woff  = (CW+1)'(r_idx);
                w_wdata = w_rdata;
                w_roff  = w_idx_p2;
                n_idx   = r_idx + AW'(1);
                if (w_shift_last) begin
                    n_count = r_count - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= clds_pkg::S_IDLE;
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == clds_pkg::S_IDLE && i_start) begin
            r_req   <= i_req_type;
            r_value <= i_value;
        end
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_status  <= n_status;
        r_removed <= n_removed;
    end

    assign w_pos_ext = (AW+clds_pkg::PosW)'(r_pos);
    assign w_occ_ext = (CW+clds_pkg::OccW)'(r_count);

    assign o_sts.idle = (r_state == clds_pkg::S_IDLE);
    assign o_sts.done = (r_state == clds_pkg::S_DONE) && i_out_free;

    assign o_result.status        = r_status;
    assign o_result.removed_value = r_removed;
    assign o_result.position      = w_pos_ext[clds_pkg::PosW-1:0];
    assign o_result.occupancy     = w_occ_ext[clds_pkg::OccW-1:0];

endmodule

### src/circular_list_deque_with_search.sv
// circular_list_deque_with_search: top level, request handshake, result register, checks
// depends on clds_pkg and clds_ctrl (which holds clds_ram)
`timescale 1ns / 1ps

// channel   direction  handshake           payload
// request   in         i_valid / o_ready   i_req_type, i_value
// result    out        o_valid / i_ready   o_status, o_removed_value, o_position, o_occupancy
//
// from accept to result loaded: insert and unused codes pass decode and done; remove front/back
// adds a fetch, search a scan from the head to the hit (through every entry on a miss), and
// remove value then compacts the entries behind the hit; scan and compaction together walk
// each entry once through the single read port
// reset (synchronous, active low) empties the list; entry contents are not cleared
// a new request is taken as soon as the sequencer is idle, even while the last result
// still waits in the output register; the sequencer holds only if that register is full

module circular_list_deque_with_search #(
    parameter int CAPACITY = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [clds_pkg::ReqW-1:0]            i_req_type,
    input  logic signed [clds_pkg::DataW-1:0]    i_value,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [clds_pkg::StatusW-1:0]         o_status,
    output logic signed [clds_pkg::DataW-1:0]    o_removed_value,
    output logic [clds_pkg::PosW-1:0]            o_position,
    output logic [clds_pkg::OccW-1:0]            o_occupancy
);

    clds_pkg::t_ctrl_sts w_sts;
    clds_pkg::t_result   w_result;
    clds_pkg::t_result   r_result;
    logic                r_out_valid;
    logic                w_start;
    logic                w_out_free;

    // request accepted whenever the sequencer is idle
    assign o_ready    = w_sts.idle;
    assign w_start    = i_valid && w_sts.idle;
    // result register can take a new item if empty or being drained this cycle
    assign w_out_free = !r_out_valid || i_ready;

    clds_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_req_type (i_req_type),
        .i_value    (i_value),
        .i_out_free (w_out_free),
        .o_sts      (w_sts),
        .o_result   (w_result)
    );

    // result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_sts.done) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_sts.done) begin
            r_result <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_result.status;
    assign o_removed_value = r_result.removed_value;
    assign o_position      = r_result.position;
    assign o_occupancy     = r_result.occupancy;

`ifndef SYNTHESIS
    // sequencer never overwrites a result that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (!r_out_valid || i_ready))
        else $error("result register overwritten");

    // one request at a time: after an accept the sequencer is busy
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while busy");

    // a full report goes with a full list
    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == clds_pkg::ST_FULL) |->
            (o_occupancy == clds_pkg::OccW'(CAPACITY)))
        else $error("full status with list not full");

    // an empty report goes with an empty list
    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == clds_pkg::ST_EMPTY) |-> (o_occupancy == '0))
        else $error("empty status with entries held");
`endif

endmodule
